[rtl/qte_pkg.sv]
// qte_pkg: shared types, widths and constants for the quaternion to euler bins block
// holds the cordic arctangent table and the pre-rotation helper
// no dependencies
`default_nettype none
package qte_pkg;

	localparam int BIN_W    = 8;
	localparam int BINS_DEF = 18;
	localparam int OUT_W    = 5;

	localparam int OP_W     = 34;
	localparam int S_W      = 30;
	localparam int CW       = 44;
	localparam int AW       = 34;

	localparam int SQ_STEPS = 29;
	localparam int RAD_W    = 2 * SQ_STEPS;
	localparam int REM_W    = 31;
	localparam int ROOT_W   = SQ_STEPS;

	localparam int CD_ITERS = 24;

	localparam logic signed [OP_W-1:0] Q28_ONE = 34'sd268435456;
	localparam logic signed [AW-1:0]   ANG_QTR = 34'sd1073741824;
	localparam logic signed [AW-1:0]   ANG_HALF = 34'sd2147483648;

	localparam logic signed [AW-1:0] ATAN_TAB [CD_ITERS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
		34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
		34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
		34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
		34'sd652, 34'sd326, 34'sd163, 34'sd81
	};

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic signed [OP_W-1:0] roll_n;
		logic signed [OP_W-1:0] roll_d;
		logic signed [OP_W-1:0] yaw_n;
		logic signed [OP_W-1:0] yaw_d;
		logic signed [S_W-1:0]  s;
	} side_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] z;
		logic                 hold;
	} lane_t;

	typedef lane_t [2:0] trio_t;

	// operands scaled by 256, left half plane rotated by a quarter turn, zero x held
	function automatic lane_t pre_rot(input logic signed [OP_W-1:0] y,
			input logic signed [OP_W-1:0] x);
		lane_t l;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		xs = {{(CW-OP_W-8){x[OP_W-1]}}, x, 8'd0};
		ys = {{(CW-OP_W-8){y[OP_W-1]}}, y, 8'd0};
		l.x = xs;
		l.y = ys;
		l.z = '0;
		l.hold = 1'b0;
		if (x == '0) begin
			l.hold = 1'b1;
			l.x = '0;
			l.y = '0;
			if (y > 0)
				l.z = ANG_QTR;
			else if (y < 0)
				l.z = -ANG_QTR;
		end else if (xs < 0) begin
			if (ys >= 0) begin
				l.z = ANG_QTR;
				l.x = ys;
				l.y = -xs;
			end else begin
				l.z = -ANG_QTR;
				l.x = -ys;
				l.y = xs;
			end
		end
		return l;
	endfunction

endpackage
`default_nettype wire

[rtl/quaternion_to_euler_bins.sv]
// quaternion_to_euler_bins: unit quaternion in, roll / pitch / yaw bin numbers out
// square root and cordic chains of cells; uses qte_pkg, qte_sqrt_cell, qte_cordic_cell
//
// input channel quat_valid / quat_stall carries w, x, y, z in signed Q1.14.
// output channel bin_valid / bin_stall carries roll_bin, pitch_bin, yaw_bin,
// one result for every request, in order.
// throughput: one request per cycle unless bin_stall holds the output, set by the
// fully pipelined cells. the pipeline has 59 register stages: three product stages,
// 29 square root cells, one pre-rotation stage, 24 cordic cells, one clamp stage
// and the output register.
// each stage holds when it is full and the one after it cannot move, so
// bubbles close up and requests keep being taken while a result waits.
// quat_stall rises only once every stage is full behind a stalled output.
// reset empties all stages; nothing is kept between requests.
`default_nettype none
module quaternion_to_euler_bins #(
	parameter int BINS = qte_pkg::BINS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           quat_valid,
	output logic                                quat_stall,
	input  wire logic signed [15:0]             quat_w,
	input  wire logic signed [15:0]             quat_x,
	input  wire logic signed [15:0]             quat_y,
	input  wire logic signed [15:0]             quat_z,
	output logic                                bin_valid,
	input  wire logic                           bin_stall,
	output logic [qte_pkg::OUT_W-1:0]           roll_bin,
	output logic [qte_pkg::OUT_W-1:0]           pitch_bin,
	output logic [qte_pkg::OUT_W-1:0]           yaw_bin
);
	import qte_pkg::*;

	localparam logic [BIN_W-1:0] BINS_V = BIN_W'(BINS);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, bin_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_out;
	logic sq_vld [SQ_STEPS+1];
	logic sq_rdy [SQ_STEPS];
	logic cd_vld [CD_ITERS+1];
	logic cd_rdy [CD_ITERS];
	sq_t   sq_d [SQ_STEPS+1];
	side_t sd_d [SQ_STEPS+1];
	trio_t cd_d [CD_ITERS+1];

	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;
	side_t side_s2;
	side_t side_s3;
	sq_t   sq_s3;
	trio_t trio_s4;
	logic [32:0] u_s5 [3];

	// stage readiness ripples back from the output register
	assign rdy_out = !bin_valid_q || !bin_stall;
	assign rdy_s5 = !v_s5 || rdy_out;
	genvar g;
	generate
		for (g = 0; g < CD_ITERS; g++) begin : g_cd_rdy
			if (g == CD_ITERS - 1) begin : g_last
				assign cd_rdy[g] = !cd_vld[g+1] || rdy_s5;
			end else begin : g_mid
				assign cd_rdy[g] = !cd_vld[g+1] || cd_rdy[g+1];
			end
		end
		for (g = 0; g < SQ_STEPS; g++) begin : g_sq_rdy
			if (g == SQ_STEPS - 1) begin : g_last
				assign sq_rdy[g] = !sq_vld[g+1] || rdy_s4;
			end else begin : g_mid
				assign sq_rdy[g] = !sq_vld[g+1] || sq_rdy[g+1];
			end
		end
	endgenerate
	assign rdy_s4 = !v_s4 || cd_rdy[0];
	assign rdy_s3 = !v_s3 || sq_rdy[0];
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign quat_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			bin_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= quat_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= sq_vld[SQ_STEPS];
			if (rdy_s5) v_s5 <= cd_vld[CD_ITERS];
			if (rdy_out) bin_valid_q <= v_s5;
		end
	end

	// products of component pairs
	always_ff @(posedge clk) begin
		if (rdy_s1 && quat_valid) begin
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			wz_s1 <= quat_w * quat_z;
			xy_s1 <= quat_x * quat_y;
			zz_s1 <= quat_z * quat_z;
			wy_s1 <= quat_w * quat_y;
			zx_s1 <= quat_z * quat_x;
		end
	end

	// arctangent operands and the clamped arcsine argument
	logic signed [OP_W-1:0] s_raw;
	always_comb begin
		s_raw = (OP_W'(wy_s1) - OP_W'(zx_s1)) <<< 1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			side_s2.roll_n <= (OP_W'(wx_s1) + OP_W'(yz_s1)) <<< 1;
			side_s2.roll_d <= Q28_ONE - ((OP_W'(xx_s1) + OP_W'(yy_s1)) <<< 1);
			side_s2.yaw_n <= (OP_W'(wz_s1) + OP_W'(xy_s1)) <<< 1;
			side_s2.yaw_d <= Q28_ONE - ((OP_W'(yy_s1) + OP_W'(zz_s1)) <<< 1);
			if (s_raw > Q28_ONE)
				side_s2.s <= S_W'(Q28_ONE);
			else if (s_raw < -Q28_ONE)
				side_s2.s <= S_W'(-Q28_ONE);
			else
				side_s2.s <= S_W'(s_raw);
		end
	end

	// radicand 1 - s*s for the cosine
	logic [ROOT_W-1:0] s_abs;
	logic [RAD_W-1:0]  s_sq;
	always_comb begin
		s_abs = side_s2.s[S_W-1] ? ROOT_W'(-side_s2.s) : ROOT_W'(side_s2.s);
		s_sq = RAD_W'(s_abs) * RAD_W'(s_abs);
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			side_s3 <= side_s2;
			sq_s3.rad <= (RAD_W'(1) << 56) - s_sq;
			sq_s3.rem <= '0;
			sq_s3.root <= '0;
		end
	end

	assign sq_vld[0] = v_s3;
	assign sq_d[0] = sq_s3;
	assign sd_d[0] = side_s3;

	generate
		for (g = 0; g < SQ_STEPS; g++) begin : g_sq
			qte_sqrt_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ld       (sq_rdy[g]),
				.in_vld   (sq_vld[g]),
				.in_sq    (sq_d[g]),
				.in_side  (sd_d[g]),
				.out_vld  (sq_vld[g+1]),
				.out_sq   (sq_d[g+1]),
				.out_side (sd_d[g+1])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (rdy_s4 && sq_vld[SQ_STEPS]) begin
			trio_s4[0] <= pre_rot(sd_d[SQ_STEPS].roll_n, sd_d[SQ_STEPS].roll_d);
			trio_s4[1] <= pre_rot(OP_W'(sd_d[SQ_STEPS].s),
				OP_W'({1'b0, sq_d[SQ_STEPS].root}));
			trio_s4[2] <= pre_rot(sd_d[SQ_STEPS].yaw_n, sd_d[SQ_STEPS].yaw_d);
		end
	end

	assign cd_vld[0] = v_s4;
	assign cd_d[0] = trio_s4;

	generate
		for (g = 0; g < CD_ITERS; g++) begin : g_cd
			qte_cordic_cell #(.ITER(g)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ld      (cd_rdy[g]),
				.in_vld  (cd_vld[g]),
				.in_t    (cd_d[g]),
				.out_vld (cd_vld[g+1]),
				.out_t   (cd_d[g+1])
			);
		end
	endgenerate

	// clamp and offset so every angle starts at zero
	logic signed [AW-1:0] a_roll, a_pitch, a_yaw;
	logic signed [AW-1:0] c_roll, c_pitch, c_yaw;
	always_comb begin
		a_roll = cd_d[CD_ITERS][0].z;
		a_pitch = cd_d[CD_ITERS][1].z;
		a_yaw = cd_d[CD_ITERS][2].z;
		c_roll = (a_roll > ANG_HALF) ? ANG_HALF : (a_roll < -ANG_HALF) ? -ANG_HALF : a_roll;
		c_yaw = (a_yaw > ANG_HALF) ? ANG_HALF : (a_yaw < -ANG_HALF) ? -ANG_HALF : a_yaw;
		c_pitch = (a_pitch > ANG_QTR) ? ANG_QTR :
			(a_pitch < -ANG_QTR) ? -ANG_QTR : a_pitch;
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && cd_vld[CD_ITERS]) begin
			u_s5[0] <= 33'(c_roll + ANG_HALF);
			u_s5[1] <= 33'(c_pitch + ANG_QTR);
			u_s5[2] <= 33'(c_yaw + ANG_HALF);
		end
	end

	logic [40:0] p_roll, p_pitch, p_yaw;
	always_comb begin
		p_roll = 41'(u_s5[0]) * 41'(BINS_V);
		p_pitch = 41'(u_s5[1]) * 41'(BINS_V);
		p_yaw = 41'(u_s5[2]) * 41'(BINS_V);
	end

	logic [OUT_W-1:0] roll_q, pitch_q, yaw_q;
	always_ff @(posedge clk) begin
		if (rdy_out && v_s5) begin
			roll_q <= p_roll[32 +: OUT_W];
			pitch_q <= p_pitch[31 +: OUT_W];
			yaw_q <= p_yaw[32 +: OUT_W];
		end
	end

	assign bin_valid = bin_valid_q;
	assign roll_bin = roll_q;
	assign pitch_bin = pitch_q;
	assign yaw_bin = yaw_q;

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(quat_valid && !quat_stall) |=> v_s1)
		else $error("accepted request did not enter first stage");
	a_roll_rng: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid_q |-> (BINS > 31) || (roll_q <= OUT_W'(BINS)))
		else $error("roll bin above range");
	a_pitch_rng: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid_q |-> (BINS > 31) || (pitch_q <= OUT_W'(BINS)))
		else $error("pitch bin above range");
	a_yaw_rng: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid_q |-> (BINS > 31) || (yaw_q <= OUT_W'(BINS)))
		else $error("yaw bin above range");

endmodule
`default_nettype wire

[rtl/qte_sqrt_cell.sv]
// qte_sqrt_cell: one digit step of the restoring integer square root
// carries the angle operands alongside; uses qte_pkg
`default_nettype none
module qte_sqrt_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           ld,
	input  wire logic           in_vld,
	input  wire qte_pkg::sq_t   in_sq,
	input  wire qte_pkg::side_t in_side,
	output logic                out_vld,
	output qte_pkg::sq_t        out_sq,
	output qte_pkg::side_t      out_side
);
	import qte_pkg::*;

	logic [REM_W+1:0] cur;
	logic [REM_W+1:0] trial;
	sq_t              nxt;

	always_comb begin
		cur = {in_sq.rem, in_sq.rad[RAD_W-1 -: 2]};
		trial = {2'b00, in_sq.root, 2'b01};
		nxt.rad = {in_sq.rad[RAD_W-3:0], 2'b00};
		if (cur >= trial) begin
			nxt.rem = REM_W'(cur - trial);
			nxt.root = {in_sq.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem = cur[REM_W-1:0];
			nxt.root = {in_sq.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else if (ld)
			out_vld <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (ld && in_vld) begin
			out_sq <= nxt;
			out_side <= in_side;
		end
	end

endmodule
`default_nettype wire

[rtl/qte_cordic_cell.sv]
// qte_cordic_cell: one vectoring cordic micro-rotation on three lanes
// roll, pitch and yaw; uses qte_pkg
`default_nettype none
module qte_cordic_cell #(
	parameter int ITER = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           ld,
	input  wire logic           in_vld,
	input  wire qte_pkg::trio_t in_t,
	output logic                out_vld,
	output qte_pkg::trio_t      out_t
);
	import qte_pkg::*;

	trio_t nxt;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			nxt[l] = in_t[l];
			// lanes resolved up front keep their angle
			if (!in_t[l].hold) begin
				if (in_t[l].y > 0) begin
					nxt[l].x = in_t[l].x + (in_t[l].y >>> ITER);
					nxt[l].y = in_t[l].y - (in_t[l].x >>> ITER);
					nxt[l].z = in_t[l].z + ATAN_TAB[ITER];
				end else begin
					nxt[l].x = in_t[l].x - (in_t[l].y >>> ITER);
					nxt[l].y = in_t[l].y + (in_t[l].x >>> ITER);
					nxt[l].z = in_t[l].z - ATAN_TAB[ITER];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else if (ld)
			out_vld <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (ld && in_vld)
			out_t <= nxt;
	end

endmodule
`default_nettype wire

[bench/quaternion_to_euler_bins_tb.sv]
// quaternion_to_euler_bins_tb: self-checking bench for the quaternion to euler bins block
// predicts roll / pitch / yaw bins with an own cordic and square root; depends on qte_pkg
`timescale 1ns / 100ps
`default_nettype none

class bin_scoreboard;
	typedef struct {
		logic [4:0] roll;
		logic [4:0] pitch;
		logic [4:0] yaw;
	} bins_t;

	bins_t pending_bins[$];
	int unsigned errors;
	int unsigned checked;

	static function longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	static function longint isqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	// binary angle, 2^32 per turn
	static function longint bin_angle(longint y, longint x);
		longint ang;
		longint t;
		longint dx;
		longint dy;
		longint atan_val[24];
		atan_val = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772,
			166886, 83443, 41722, 20861, 10430, 5215,
			2608, 1304, 652, 326, 163, 81};
		ang = 0;
		if (x == 0)
			return y > 0 ? 64'sd1073741824 : (y < 0 ? -64'sd1073741824 : 0);
		x = x * 256;
		y = y * 256;
		if (x < 0) begin
			if (y >= 0) begin
				ang = 64'sd1073741824;
				t = x; x = y; y = -t;
			end else begin
				ang = -64'sd1073741824;
				t = x; x = -y; y = t;
			end
		end
		for (int i = 0; i < 24; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (y > 0) begin
				x += dx; y -= dy; ang += atan_val[i];
			end else begin
				x -= dx; y += dy; ang -= atan_val[i];
			end
		end
		return ang;
	endfunction

	static function logic [4:0] full_bin(longint a);
		longint unsigned p;
		if (a > 64'sd2147483648) a = 64'sd2147483648;
		if (a < -64'sd2147483648) a = -64'sd2147483648;
		p = (longint'(a + 64'sd2147483648) * 18) >> 32;
		return p[4:0];
	endfunction

	static function logic [4:0] half_bin(longint a);
		longint unsigned p;
		if (a > 64'sd1073741824) a = 64'sd1073741824;
		if (a < -64'sd1073741824) a = -64'sd1073741824;
		p = (longint'(a + 64'sd1073741824) * 18) >> 31;
		return p[4:0];
	endfunction

	function void note_request(logic signed [15:0] qw, logic signed [15:0] qx,
			logic signed [15:0] qy, logic signed [15:0] qz);
		longint w, x, y, z, s, c;
		longint unsigned sa;
		bins_t b;
		w = qw; x = qx; y = qy; z = qz;
		s = 2 * (w * y - z * x);
		if (s > 64'sd268435456) s = 64'sd268435456;
		if (s < -64'sd268435456) s = -64'sd268435456;
		sa = s < 0 ? -s : s;
		c = isqrt((64'd1 << 56) - sa * sa);
		b.roll = full_bin(bin_angle(2 * (w * x + y * z), 64'sd268435456 - 2 * (x * x + y * y)));
		b.pitch = half_bin(bin_angle(s, c));
		b.yaw = full_bin(bin_angle(2 * (w * z + x * y), 64'sd268435456 - 2 * (y * y + z * z)));
		pending_bins.insert(pending_bins.size(), b);
	endfunction

	function void check_result(logic [4:0] roll, logic [4:0] pitch, logic [4:0] yaw);
		bins_t b;
		if (pending_bins.size() == 0) begin
			$error("result with no request outstanding: %0d %0d %0d", roll, pitch, yaw);
			errors++;
			return;
		end
		b = pending_bins.pop_front();
		checked++;
		if (roll !== b.roll) begin
			$error("roll_bin expected %0d actual %0d", b.roll, roll);
			errors++;
		end
		if (pitch !== b.pitch) begin
			$error("pitch_bin expected %0d actual %0d", b.pitch, pitch);
			errors++;
		end
		if (yaw !== b.yaw) begin
			$error("yaw_bin expected %0d actual %0d", b.yaw, yaw);
			errors++;
		end
	endfunction
endclass

module quaternion_to_euler_bins_tb;
	localparam int LATENCY = 59;
	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic quat_valid;
	logic quat_stall;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	logic bin_valid;
	logic bin_stall;
	logic [4:0] roll_bin, pitch_bin, yaw_bin;

	bin_scoreboard sb;
	int unsigned cycles;
	int unsigned sent;
	bit idle_en;
	bit hold_off;

	quaternion_to_euler_bins dut (
		.clk(clk), .arst_n(arst_n),
		.quat_valid(quat_valid), .quat_stall(quat_stall),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.bin_valid(bin_valid), .bin_stall(bin_stall),
		.roll_bin(roll_bin), .pitch_bin(pitch_bin), .yaw_bin(yaw_bin)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// receiver side: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (!arst_n) begin
			bin_stall <= 1'b0;
		end else begin
			if (bin_valid && !bin_stall)
				sb.check_result(roll_bin, pitch_bin, yaw_bin);
			bin_stall <= hold_off || (idle_en && $urandom_range(99) < 35);
		end
	end

	task automatic send_quat(input logic [15:0] w, x, y, z);
		while (idle_en && $urandom_range(99) < 35) begin
			quat_valid <= 1'b0;
			@(posedge clk);
		end
		quat_valid <= 1'b1;
		quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
		@(posedge clk);
		while (quat_stall)
			@(posedge clk);
		sb.note_request(w, x, y, z);
		sent++;
	endtask

	task automatic drain_bins();
		quat_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_bins.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(9))
			0: return 16'($urandom_range(2) == 0 ? -16384 : ($urandom_range(1) ? 16384 : 0));
			1: return 16'($urandom);
			default: return 16'(int'($urandom_range(32768)) - 16384);
		endcase
	endfunction

	// roughly unit quaternion from a random direction
	task automatic send_unit_quat();
		real a, b, c, d, n;
		a = real'(int'($urandom_range(2000)) - 1000);
		b = real'(int'($urandom_range(2000)) - 1000);
		c = real'(int'($urandom_range(2000)) - 1000);
		d = real'(int'($urandom_range(2000)) - 1000);
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n == 0.0) n = 1.0;
		send_quat(16'(int'(a / n * 16384.0)), 16'(int'(b / n * 16384.0)),
			16'(int'(c / n * 16384.0)), 16'(int'(d / n * 16384.0)));
	endtask

	initial begin
		sb = new();
		quat_valid = 1'b0;
		quat_w = '0; quat_x = '0; quat_y = '0; quat_z = '0;
		@(posedge arst_n);
		@(posedge clk);
		// directed: identity, axes, gimbal lock, zero, extremes
		send_quat(16384, 0, 0, 0);
		send_quat(-16384, 0, 0, 0);
		send_quat(0, 16384, 0, 0);
		send_quat(0, 0, 16384, 0);
		send_quat(0, 0, 0, 16384);
		send_quat(11585, 0, 11585, 0);
		send_quat(11585, 0, -11585, 0);
		send_quat(11585, 11585, 0, 0);
		send_quat(11585, 0, 0, 11585);
		send_quat(0, 0, 0, 0);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		send_quat(16384, 16384, 16384, 16384);
		send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
		send_quat(8192, -8192, 8192, -8192);
		send_quat(0, -16384, 0, 0);
		// burst with no idling
		repeat (100) send_unit_quat();
		drain_bins();
		idle_en = 1'b1;
		repeat (200) begin
			if ($urandom_range(3) == 0)
				send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
			else
				send_unit_quat();
		end
		// sender pauses until everything is back
		drain_bins();
		// receiver holds off long enough to back up the pipeline
		idle_en = 1'b0;
		hold_off = 1'b1;
		fork
			begin
				repeat (150) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (100) send_unit_quat();
		join
		idle_en = 1'b1;
		repeat (100) send_unit_quat();
		drain_bins();
		repeat (LATENCY + 10) @(posedge clk);
		$display("sent %0d quaternions, checked %0d bin triples, incl. axes, zero and saturation",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending_bins.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
rtl/qte_pkg.sv
rtl/qte_sqrt_cell.sv
rtl/qte_cordic_cell.sv
rtl/quaternion_to_euler_bins.sv
bench/quaternion_to_euler_bins_tb.sv
